// ----- rtl/fjot_pkg.sv -----
`timescale 1ns / 1ps

package fjot_pkg;

    typedef enum logic [4:0] {
        PH_FIRST,
        PH_BOM1,
        PH_BOM2,
        PH_LEAD,
        PH_KEY_OPEN,
        PH_KEY_STR,
        PH_KEY_ESC,
        PH_COLON,
        PH_VALUE,
        PH_VAL_STR,
        PH_VAL_ESC,
        PH_LITERAL,
        PH_NUMBER,
        PH_AFTER_VAL,
        PH_TRAIL,
        PH_ACCEPTED,
        PH_FAILED
    } phase_t;

    typedef enum logic [2:0] {
        NUM_INT,
        NUM_FRAC,
        NUM_EXP,
        NUM_EXP_SIGN,
        NUM_EXP_DIG
    } num_phase_t;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_VAL  = 2'd2;
    localparam logic [1:0] KIND_PAIR = 2'd3;

    localparam logic [1:0] STAT_BUSY   = 2'd0;
    localparam logic [1:0] STAT_ACCEPT = 2'd1;
    localparam logic [1:0] STAT_FAIL   = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_ROOT       = 4'd1;
    localparam logic [3:0] ERR_EOT_OBJ    = 4'd2;
    localparam logic [3:0] ERR_KEY_QUOTE  = 4'd3;
    localparam logic [3:0] ERR_EOT_ESC    = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd5;
    localparam logic [3:0] ERR_UNTERM     = 4'd6;
    localparam logic [3:0] ERR_COLON      = 4'd7;
    localparam logic [3:0] ERR_NO_VALUE   = 4'd8;
    localparam logic [3:0] ERR_BAD_VALUE  = 4'd9;
    localparam logic [3:0] ERR_EOT_VALUE  = 4'd10;
    localparam logic [3:0] ERR_SEPARATOR  = 4'd11;
    localparam logic [3:0] ERR_TRAILING   = 4'd12;

    localparam logic [7:0] BOM_0 = 8'hEF;
    localparam logic [7:0] BOM_1 = 8'hBB;
    localparam logic [7:0] BOM_2 = 8'hBF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [1:0] status;
        logic [3:0] err;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic esc_ok(input logic [7:0] c);
        return c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"};
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c);
        logic [7:0] d;
        case (c)
            "b":     d = 8'h08;
            "f":     d = 8'h0C;
            "n":     d = 8'h0A;
            "r":     d = 8'h0D;
            "t":     d = 8'h09;
            default: d = c;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_value(input logic [1:0] k);
        return (k == 2'd0) ? "1" : "0";
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] t;
        case ({k, p})
            {2'd0, 3'd0}: t = "t";
            {2'd0, 3'd1}: t = "r";
            {2'd0, 3'd2}: t = "u";
            {2'd0, 3'd3}: t = "e";
            {2'd1, 3'd0}: t = "f";
            {2'd1, 3'd1}: t = "a";
            {2'd1, 3'd2}: t = "l";
            {2'd1, 3'd3}: t = "s";
            {2'd1, 3'd4}: t = "e";
            {2'd2, 3'd0},
            {2'd3, 3'd0}: t = "n";
            {2'd2, 3'd1},
            {2'd3, 3'd1}: t = "u";
            {2'd2, 3'd2},
            {2'd3, 3'd2},
            {2'd2, 3'd3},
            {2'd3, 3'd3}: t = "l";
            default:      t = 8'h00;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/fjot_in_reg.sv -----
`timescale 1ns / 1ps

module fjot_in_reg
    import fjot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  item_t req_item,
    input  logic  drain,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign req_stall = valid_reg && !drain;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= req_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- rtl/fjot_parser.sv -----
`timescale 1ns / 1ps

module fjot_parser
    import fjot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    phase_t     phase_reg, phase_next;
    logic [1:0] lkind_reg, lkind_next;
    logic [2:0] lpos_reg, lpos_next;
    num_phase_t nphase_reg, nphase_next;
    logic       mant_reg, mant_next;
    logic       expd_reg, expd_next;
    logic [3:0] err_reg, err_next;

    logic [1:0] res_kind;
    logic [7:0] res_ch;
    logic [3:0] fail_code;
    logic       av;
    logic [7:0] c;
    logic [2:0] pos_inc;

    assign c       = item.data_byte;
    assign pos_inc = lpos_reg + 3'd1;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        lkind_next  = lkind_reg;
        lpos_next   = lpos_reg;
        nphase_next = nphase_reg;
        mant_next   = mant_reg;
        expd_next   = expd_reg;
        err_next    = err_reg;
        res_kind    = KIND_NONE;
        res_ch      = 8'h00;
        fail_code   = ERR_NONE;
        av          = 1'b0;

        if (phase_reg != PH_ACCEPTED && phase_reg != PH_FAILED)
        begin
            if (item.req_type == REQ_END)
            begin
                case (phase_reg)
                    PH_FIRST, PH_BOM1, PH_BOM2, PH_LEAD: fail_code = ERR_ROOT;
                    PH_KEY_OPEN:                         fail_code = ERR_EOT_OBJ;
                    PH_KEY_STR, PH_VAL_STR:              fail_code = ERR_UNTERM;
                    PH_KEY_ESC, PH_VAL_ESC:              fail_code = ERR_EOT_ESC;
                    PH_COLON:                            fail_code = ERR_COLON;
                    PH_VALUE:                            fail_code = ERR_NO_VALUE;
                    PH_LITERAL:                          fail_code = ERR_BAD_VALUE;
                    PH_NUMBER:
                    begin
                        if (nphase_reg == NUM_INT || nphase_reg == NUM_FRAC)
                            fail_code = mant_reg ? ERR_EOT_VALUE : ERR_BAD_VALUE;
                        else if (nphase_reg == NUM_EXP_DIG && expd_reg)
                            fail_code = ERR_EOT_VALUE;
                        else
                            fail_code = ERR_BAD_VALUE;
                    end
                    PH_AFTER_VAL:                        fail_code = ERR_EOT_VALUE;
                    PH_TRAIL:                            phase_next = PH_ACCEPTED;
                    default:                             ;
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST, PH_LEAD:
                    begin
                        if (phase_reg == PH_FIRST && c == BOM_0)
                            phase_next = PH_BOM1;
                        else if (is_ws(c))
                            phase_next = PH_LEAD;
                        else if (c == "{")
                            phase_next = PH_KEY_OPEN;
                        else
                            fail_code = ERR_ROOT;
                    end
                    PH_BOM1:
                    begin
                        if (c == BOM_1)
                            phase_next = PH_BOM2;
                        else
                            fail_code = ERR_ROOT;
                    end
                    PH_BOM2:
                    begin
                        if (c == BOM_2)
                            phase_next = PH_LEAD;
                        else
                            fail_code = ERR_ROOT;
                    end
                    PH_KEY_OPEN:
                    begin
                        if (is_ws(c))
                            phase_next = PH_KEY_OPEN;
                        else if (c == "}")
                            phase_next = PH_TRAIL;
                        else if (c == "\"")
                            phase_next = PH_KEY_STR;
                        else
                            fail_code = ERR_KEY_QUOTE;
                    end
                    PH_KEY_STR:
                    begin
                        if (c == "\"")
                            phase_next = PH_COLON;
                        else if (c == "\\")
                            phase_next = PH_KEY_ESC;
                        else
                        begin
                            res_kind = KIND_KEY;
                            res_ch   = c;
                        end
                    end
                    PH_VAL_STR:
                    begin
                        if (c == "\"")
                            phase_next = PH_AFTER_VAL;
                        else if (c == "\\")
                            phase_next = PH_VAL_ESC;
                        else
                        begin
                            res_kind = KIND_VAL;
                            res_ch   = c;
                        end
                    end
                    PH_KEY_ESC, PH_VAL_ESC:
                    begin
                        if (!esc_ok(c))
                            fail_code = ERR_BAD_ESC;
                        else
                        begin
                            res_kind   = (phase_reg == PH_KEY_ESC) ? KIND_KEY : KIND_VAL;
                            res_ch     = esc_char(c);
                            phase_next = (phase_reg == PH_KEY_ESC) ? PH_KEY_STR : PH_VAL_STR;
                        end
                    end
                    PH_COLON:
                    begin
                        if (c == ":")
                            phase_next = PH_VALUE;
                        else if (!is_ws(c))
                            fail_code = ERR_COLON;
                    end
                    PH_VALUE:
                    begin
                        if (is_ws(c))
                            phase_next = PH_VALUE;
                        else if (c == "\"")
                            phase_next = PH_VAL_STR;
                        else if (c inside {"t", "f", "n"})
                        begin
                            lkind_next = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                            lpos_next  = 3'd1;
                            phase_next = PH_LITERAL;
                        end
                        else if (c inside {"+", "-", "."} || is_digit(c))
                        begin
                            nphase_next = (c == ".") ? NUM_FRAC : NUM_INT;
                            mant_next   = is_digit(c);
                            expd_next   = 1'b0;
                            phase_next  = PH_NUMBER;
                            res_kind    = KIND_VAL;
                            res_ch      = c;
                        end
                        else
                            fail_code = ERR_BAD_VALUE;
                    end
                    PH_LITERAL:
                    begin
                        if (lpos_reg < lit_len(lkind_reg)
                                && c == lit_char(lkind_reg, lpos_reg))
                        begin
                            lpos_next = pos_inc;
                            if (pos_inc == lit_len(lkind_reg))
                            begin
                                res_kind   = KIND_VAL;
                                res_ch     = lit_value(lkind_reg);
                                phase_next = PH_AFTER_VAL;
                            end
                        end
                        else
                            fail_code = ERR_BAD_VALUE;
                    end
                    PH_NUMBER:
                    begin
                        case (nphase_reg)
                            NUM_INT, NUM_FRAC:
                            begin
                                if (is_digit(c))
                                begin
                                    mant_next = 1'b1;
                                    res_kind  = KIND_VAL;
                                    res_ch    = c;
                                end
                                else if (nphase_reg == NUM_INT && c == ".")
                                begin
                                    nphase_next = NUM_FRAC;
                                    res_kind    = KIND_VAL;
                                    res_ch      = c;
                                end
                                else if (!mant_reg)
                                    fail_code = ERR_BAD_VALUE;
                                else if (c inside {"e", "E"})
                                begin
                                    nphase_next = NUM_EXP;
                                    res_kind    = KIND_VAL;
                                    res_ch      = c;
                                end
                                else
                                    av = 1'b1;
                            end
                            NUM_EXP, NUM_EXP_SIGN:
                            begin
                                if (nphase_reg == NUM_EXP && c inside {"+", "-"})
                                begin
                                    nphase_next = NUM_EXP_SIGN;
                                    res_kind    = KIND_VAL;
                                    res_ch      = c;
                                end
                                else if (is_digit(c))
                                begin
                                    nphase_next = NUM_EXP_DIG;
                                    expd_next   = 1'b1;
                                    res_kind    = KIND_VAL;
                                    res_ch      = c;
                                end
                                else
                                    fail_code = ERR_BAD_VALUE;
                            end
                            default:
                            begin
                                if (is_digit(c))
                                begin
                                    res_kind = KIND_VAL;
                                    res_ch   = c;
                                end
                                else
                                    av = 1'b1;
                            end
                        endcase
                    end
                    PH_AFTER_VAL:
                        av = 1'b1;
                    PH_TRAIL:
                    begin
                        if (!is_ws(c))
                            fail_code = ERR_TRAILING;
                    end
                    default: ;
                endcase

                if (av)
                begin
                    phase_next = PH_AFTER_VAL;
                    if (c == ",")
                    begin
                        res_kind   = KIND_PAIR;
                        phase_next = PH_KEY_OPEN;
                    end
                    else if (c == "}")
                    begin
                        res_kind   = KIND_PAIR;
                        phase_next = PH_TRAIL;
                    end
                    else if (!is_ws(c))
                        fail_code = ERR_SEPARATOR;
                end
            end

            if (fail_code != ERR_NONE)
            begin
                phase_next = PH_FAILED;
                err_next   = fail_code;
            end
        end
    end

    // result word
    always_comb
    begin
        result.kind = res_kind;
        result.ch   = res_ch;
        case (phase_next)
            PH_ACCEPTED: result.status = STAT_ACCEPT;
            PH_FAILED:   result.status = STAT_FAIL;
            default:     result.status = STAT_BUSY;
        endcase
        result.err = (phase_next == PH_FAILED) ? err_next : ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            lkind_reg  <= 2'd0;
            lpos_reg   <= 3'd0;
            nphase_reg <= NUM_INT;
            mant_reg   <= 1'b0;
            expd_reg   <= 1'b0;
            err_reg    <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            lkind_reg  <= lkind_next;
            lpos_reg   <= lpos_next;
            nphase_reg <= nphase_next;
            mant_reg   <= mant_next;
            expd_reg   <= expd_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- rtl/fjot_out_reg.sv -----
`timescale 1ns / 1ps

module fjot_out_reg
    import fjot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output result_t rsp_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!rsp_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= result;
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = word_reg;

endmodule

// ----- rtl/flat_json_object_tokenizer.sv -----
`timescale 1ns / 1ps
// channel   valid       stall       word
// request   req_valid   req_stall   req_type, data_byte
// response  rsp_valid   rsp_stall   out_kind, out_char, parse_status, error_code
//
// One response word per request word; one word per cycle sustained while the response side does not stall.
// A request word passes through the input register, then the parse step into the result register.
// Reset returns the parser to the start of text; it also clears both valid flags.
// A response stall holds the result register and backs up through the input register.

module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] out_kind,
    output logic [7:0] out_char,
    output logic [1:0] parse_status,
    output logic [3:0] error_code
);

    item_t   req_item;
    item_t   held_item;
    logic    held_valid;
    logic    free;
    logic    step;
    result_t result;
    result_t rsp_word;

    assign req_item.req_type  = req_type;
    assign req_item.data_byte = data_byte;
    assign step               = held_valid && free;

    fjot_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .drain      (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    fjot_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (held_item),
        .result (result)
    );

    fjot_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result    (result),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    assign out_kind     = rsp_word.kind;
    assign out_char     = rsp_word.ch;
    assign parse_status = rsp_word.status;
    assign error_code   = rsp_word.err;

endmodule

// ----- rtl/fjot_checker.sv -----
`timescale 1ns / 1ps

module fjot_checker
    import fjot_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [1:0] out_kind,
    input logic [7:0] out_char,
    input logic [1:0] parse_status,
    input logic [3:0] error_code
);

    logic       done_reg;
    logic [1:0] status_reg;
    logic [3:0] err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= STAT_BUSY;
            err_reg    <= ERR_NONE;
        end
        else if (rsp_valid && !rsp_stall && !done_reg && parse_status != STAT_BUSY)
        begin
            done_reg   <= 1'b1;
            status_reg <= parse_status;
            err_reg    <= error_code;
        end
    end

    // outcome holds once reported
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && done_reg |->
            parse_status == status_reg && error_code == err_reg && out_kind == KIND_NONE)
        else $error("outcome changed after it was reported");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((error_code != ERR_NONE) == (parse_status == STAT_FAIL)))
        else $error("error code and status disagree");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_kind != KIND_NONE |-> parse_status == STAT_BUSY)
        else $error("token emitted with final status");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (out_kind == KIND_NONE || out_kind == KIND_PAIR) |-> out_char == 8'h00)
        else $error("character set on non-character word");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_kind) && $stable(out_char)
            && $stable(parse_status) && $stable(error_code))
        else $error("stalled response word changed");

endmodule

bind flat_json_object_tokenizer fjot_checker u_fjot_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .out_kind     (out_kind),
    .out_char     (out_char),
    .parse_status (parse_status),
    .error_code   (error_code)
);

// ----- tb/flat_json_object_tokenizer_test.sv -----
`timescale 1ns / 1ps

module flat_json_object_tokenizer_test;
    import fjot_pkg::*;

    localparam int TEXT_WORDS = 1700;
    localparam int HOLD_WORDS = 24;
    localparam int CALM_TAIL  = 150;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam result_t QUIET_WORD = '{KIND_NONE, 8'h00, STAT_BUSY, ERR_NONE};
    localparam result_t PAIR_WORD  = '{KIND_PAIR, 8'h00, STAT_BUSY, ERR_NONE};
    localparam result_t KEY_TOP    = '{KIND_KEY, 8'hFF, STAT_BUSY, ERR_NONE};
    localparam result_t KEY_ZERO   = '{KIND_KEY, 8'h00, STAT_BUSY, ERR_NONE};

    typedef struct packed {
        logic       rt;
        logic [7:0] b;
        logic       typed;
        result_t    want;
    } text_word_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic       req_type = REQ_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic [1:0] parse_status;
    logic [3:0] error_code;

    flat_json_object_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .out_kind     (out_kind),
        .out_char     (out_char),
        .parse_status (parse_status),
        .error_code   (error_code)
    );

    // BOM, a tab, key with extreme bytes and an escape, true, empty key, number -5E7
    text_word_t opening_text [25] = '{
        '{REQ_BYTE, BOM_0, 1'b1, QUIET_WORD},
        '{REQ_BYTE, BOM_1, 1'b1, QUIET_WORD},
        '{REQ_BYTE, BOM_2, 1'b1, QUIET_WORD},
        '{REQ_BYTE, 8'h09, 1'b1, QUIET_WORD},
        '{REQ_BYTE, "{",   1'b1, QUIET_WORD},
        '{REQ_BYTE, "\"",  1'b1, QUIET_WORD},
        '{REQ_BYTE, 8'hFF, 1'b1, KEY_TOP},
        '{REQ_BYTE, 8'h00, 1'b1, KEY_ZERO},
        '{REQ_BYTE, "\\",  1'b1, QUIET_WORD},
        '{REQ_BYTE, "n",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "\"",  1'b1, QUIET_WORD},
        '{REQ_BYTE, ":",   1'b1, QUIET_WORD},
        '{REQ_BYTE, "t",   1'b1, QUIET_WORD},
        '{REQ_BYTE, "r",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "u",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "e",   1'b0, QUIET_WORD},
        '{REQ_BYTE, ",",   1'b1, PAIR_WORD},
        '{REQ_BYTE, "\"",  1'b0, QUIET_WORD},
        '{REQ_BYTE, "\"",  1'b0, QUIET_WORD},
        '{REQ_BYTE, ":",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "-",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "5",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "E",   1'b0, QUIET_WORD},
        '{REQ_BYTE, "7",   1'b0, QUIET_WORD},
        '{REQ_BYTE, ",",   1'b1, PAIR_WORD}
    };

    text_word_t text_q [$];
    result_t    expected_tokens [$];
    string      escape_letters = "\"\\/bfnrt";

    text_word_t on_wire;
    result_t    prediction;
    result_t    want;
    result_t    got;
    int         send_gap = 0;
    int         stall_left = 0;
    int         mismatches = 0;
    logic       calm_stretch = 1'b0;

    // parser state as seen from outside
    phase_t     phase_now = PH_FIRST;
    logic [1:0] word_kind = LIT_TRUE;
    logic [2:0] word_pos = 3'd0;
    num_phase_t num_part = NUM_INT;
    logic       mant_digit = 1'b0;
    logic       exp_digit = 1'b0;
    logic [3:0] first_error = ERR_NONE;
    logic [1:0] step_kind;
    logic [7:0] step_char;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic string spelled_literal(input logic [1:0] k);
        return (k == LIT_TRUE) ? "true" : (k == LIT_FALSE) ? "false" : "null";
    endfunction

    function automatic void emit_char(input logic [1:0] k, input logic [7:0] c);
        step_kind = k;
        step_char = c;
    endfunction

    function automatic void set_error(input logic [3:0] e);
        phase_now = PH_FAILED;
        first_error = e;
    endfunction

    function automatic void after_value_byte(input logic [7:0] c);
        phase_now = PH_AFTER_VAL;
        if (!is_blank(c))
        begin
            if (c == ",")
            begin
                emit_char(KIND_PAIR, 8'h00);
                phase_now = PH_KEY_OPEN;
            end
            else if (c == "}")
            begin
                emit_char(KIND_PAIR, 8'h00);
                phase_now = PH_TRAIL;
            end
            else
                set_error(ERR_SEPARATOR);
        end
    endfunction

    function automatic result_t tokenize_word(input logic rt, input logic [7:0] c);
        result_t r;
        string   w;
        logic    in_key;
        logic    known;
        logic [7:0] d;
        step_kind = KIND_NONE;
        step_char = 8'h00;
        if (phase_now != PH_ACCEPTED && phase_now != PH_FAILED)
        begin
            if (rt == REQ_END)
            begin
                case (phase_now)
                    PH_FIRST, PH_BOM1, PH_BOM2, PH_LEAD: set_error(ERR_ROOT);
                    PH_KEY_OPEN:             set_error(ERR_EOT_OBJ);
                    PH_KEY_STR, PH_VAL_STR:  set_error(ERR_UNTERM);
                    PH_KEY_ESC, PH_VAL_ESC:  set_error(ERR_EOT_ESC);
                    PH_COLON:                set_error(ERR_COLON);
                    PH_VALUE:                set_error(ERR_NO_VALUE);
                    PH_LITERAL:              set_error(ERR_BAD_VALUE);
                    PH_NUMBER:
                        if (num_part == NUM_INT || num_part == NUM_FRAC)
                            set_error(mant_digit ? ERR_EOT_VALUE : ERR_BAD_VALUE);
                        else if (num_part == NUM_EXP_DIG && exp_digit)
                            set_error(ERR_EOT_VALUE);
                        else
                            set_error(ERR_BAD_VALUE);
                    PH_AFTER_VAL:            set_error(ERR_EOT_VALUE);
                    PH_TRAIL:                phase_now = PH_ACCEPTED;
                    default: ;
                endcase
            end
            else
            begin
                case (phase_now)
                    PH_FIRST, PH_LEAD:
                        if (phase_now == PH_FIRST && c == BOM_0)
                            phase_now = PH_BOM1;
                        else if (is_blank(c))
                            phase_now = PH_LEAD;
                        else if (c == "{")
                            phase_now = PH_KEY_OPEN;
                        else
                            set_error(ERR_ROOT);
                    PH_BOM1:
                        if (c == BOM_1)
                            phase_now = PH_BOM2;
                        else
                            set_error(ERR_ROOT);
                    PH_BOM2:
                        if (c == BOM_2)
                            phase_now = PH_LEAD;
                        else
                            set_error(ERR_ROOT);
                    PH_KEY_OPEN:
                        if (!is_blank(c))
                        begin
                            if (c == "}")
                                phase_now = PH_TRAIL;
                            else if (c == "\"")
                                phase_now = PH_KEY_STR;
                            else
                                set_error(ERR_KEY_QUOTE);
                        end
                    PH_KEY_STR, PH_VAL_STR:
                    begin
                        in_key = (phase_now == PH_KEY_STR);
                        if (c == "\"")
                            phase_now = in_key ? PH_COLON : PH_AFTER_VAL;
                        else if (c == "\\")
                            phase_now = in_key ? PH_KEY_ESC : PH_VAL_ESC;
                        else
                            emit_char(in_key ? KIND_KEY : KIND_VAL, c);
                    end
                    PH_KEY_ESC, PH_VAL_ESC:
                    begin
                        in_key = (phase_now == PH_KEY_ESC);
                        known = 1'b1;
                        d = c;
                        case (c)
                            "b": d = 8'h08;
                            "f": d = 8'h0C;
                            "n": d = 8'h0A;
                            "r": d = 8'h0D;
                            "t": d = 8'h09;
                            "\"", "\\", "/": ;
                            default: known = 1'b0;
                        endcase
                        if (!known)
                            set_error(ERR_BAD_ESC);
                        else
                        begin
                            emit_char(in_key ? KIND_KEY : KIND_VAL, d);
                            phase_now = in_key ? PH_KEY_STR : PH_VAL_STR;
                        end
                    end
                    PH_COLON:
                        if (!is_blank(c))
                        begin
                            if (c == ":")
                                phase_now = PH_VALUE;
                            else
                                set_error(ERR_COLON);
                        end
                    PH_VALUE:
                        if (!is_blank(c))
                        begin
                            if (c == "\"")
                                phase_now = PH_VAL_STR;
                            else if (c == "t" || c == "f" || c == "n")
                            begin
                                word_kind = (c == "t") ? LIT_TRUE :
                                            (c == "f") ? LIT_FALSE : LIT_NULL;
                                word_pos = 3'd1;
                                phase_now = PH_LITERAL;
                            end
                            else if (c == "+" || c == "-" || c == "." || is_numeral(c))
                            begin
                                num_part = (c == ".") ? NUM_FRAC : NUM_INT;
                                mant_digit = is_numeral(c);
                                exp_digit = 1'b0;
                                phase_now = PH_NUMBER;
                                emit_char(KIND_VAL, c);
                            end
                            else
                                set_error(ERR_BAD_VALUE);
                        end
                    PH_LITERAL:
                    begin
                        w = spelled_literal(word_kind);
                        if (word_pos >= w.len() || c != w[word_pos])
                            set_error(ERR_BAD_VALUE);
                        else
                        begin
                            word_pos = word_pos + 3'd1;
                            if (word_pos == w.len())
                            begin
                                emit_char(KIND_VAL, (word_kind == LIT_TRUE) ? "1" : "0");
                                phase_now = PH_AFTER_VAL;
                            end
                        end
                    end
                    PH_NUMBER:
                        case (num_part)
                            NUM_INT, NUM_FRAC:
                                if (is_numeral(c))
                                begin
                                    mant_digit = 1'b1;
                                    emit_char(KIND_VAL, c);
                                end
                                else if (num_part == NUM_INT && c == ".")
                                begin
                                    num_part = NUM_FRAC;
                                    emit_char(KIND_VAL, c);
                                end
                                else if (!mant_digit)
                                    set_error(ERR_BAD_VALUE);
                                else if (c == "e" || c == "E")
                                begin
                                    num_part = NUM_EXP;
                                    emit_char(KIND_VAL, c);
                                end
                                else
                                    after_value_byte(c);
                            NUM_EXP, NUM_EXP_SIGN:
                                if (num_part == NUM_EXP && (c == "+" || c == "-"))
                                begin
                                    num_part = NUM_EXP_SIGN;
                                    emit_char(KIND_VAL, c);
                                end
                                else if (is_numeral(c))
                                begin
                                    num_part = NUM_EXP_DIG;
                                    exp_digit = 1'b1;
                                    emit_char(KIND_VAL, c);
                                end
                                else
                                    set_error(ERR_BAD_VALUE);
                            default:
                                if (is_numeral(c))
                                    emit_char(KIND_VAL, c);
                                else
                                    after_value_byte(c);
                        endcase
                    PH_AFTER_VAL:
                        after_value_byte(c);
                    PH_TRAIL:
                        if (!is_blank(c))
                            set_error(ERR_TRAILING);
                    default: ;
                endcase
            end
        end
        r.kind = step_kind;
        r.ch = step_char;
        r.status = (phase_now == PH_ACCEPTED) ? STAT_ACCEPT :
                   (phase_now == PH_FAILED) ? STAT_FAIL : STAT_BUSY;
        r.err = (phase_now == PH_FAILED) ? first_error : ERR_NONE;
        return r;
    endfunction

    function automatic logic [7:0] any_byte_but(input string banned, input logic no_blank);
        logic [7:0] b;
        logic       hit;
        do
        begin
            b = 8'($urandom_range(0, 255));
            hit = no_blank && is_blank(b);
            for (int i = 0; i < banned.len(); i++)
                if (banned[i] == b)
                    hit = 1'b1;
        end
        while (hit);
        return b;
    endfunction

    function automatic void put(input logic rt, input logic [7:0] b);
        text_word_t w;
        w = '{rt, b, 1'b0, QUIET_WORD};
        text_q = {text_q, w};
    endfunction

    function automatic void put_end();
        put(REQ_END, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(REQ_BYTE, s[i]);
    endfunction

    function automatic void put_space();
        int n;
        int r;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 5);
            put(REQ_BYTE, (r == 5) ? 8'h20 : 8'(8'h09 + r));
        end
    endfunction

    function automatic void put_digit();
        put(REQ_BYTE, 8'(8'h30 + $urandom_range(0, 9)));
    endfunction

    function automatic void put_sign();
        case ($urandom_range(0, 2))
            1: put(REQ_BYTE, "+");
            2: put(REQ_BYTE, "-");
            default: ;
        endcase
    endfunction

    function automatic void put_chars(input int most);
        int n;
        n = $urandom_range(0, most);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                put(REQ_BYTE, "\\");
                put(REQ_BYTE, escape_letters[$urandom_range(0, 7)]);
            end
            else
                put(REQ_BYTE, any_byte_but("\"\\", 1'b0));
        end
    endfunction

    function automatic void put_key();
        put(REQ_BYTE, "\"");
        put_chars(8);
        put(REQ_BYTE, "\"");
    endfunction

    function automatic void put_pair_head();
        put_space();
        put_key();
        put_space();
        put(REQ_BYTE, ":");
        put_space();
    endfunction

    function automatic void put_number();
        int   ni;
        int   nf;
        logic dot;
        put_sign();
        ni = $urandom_range(0, 4);
        dot = ($urandom_range(0, 1) == 1);
        nf = dot ? $urandom_range(0, 3) : 0;
        if (ni + nf == 0)
            ni = 1;
        repeat (ni) put_digit();
        if (dot)
        begin
            put(REQ_BYTE, ".");
            repeat (nf) put_digit();
        end
        if ($urandom_range(0, 2) == 0)
        begin
            put(REQ_BYTE, $urandom_range(0, 1) ? "e" : "E");
            put_sign();
            repeat ($urandom_range(1, 3)) put_digit();
        end
    endfunction

    function automatic void put_value();
        case ($urandom_range(0, 3))
            0:
            begin
                put(REQ_BYTE, "\"");
                put_chars(10);
                put(REQ_BYTE, "\"");
            end
            2: put_text(spelled_literal(2'($urandom_range(0, 2))));
            default: put_number();
        endcase
    endfunction

    task automatic build_text();
        logic [3:0] ending;
        string      w;
        string      starts;
        int         cut;
        starts = "+-.";
        foreach (opening_text[i])
            text_q = {text_q, opening_text[i]};
        while (text_q.size() < TEXT_WORDS - 40)
        begin
            put_pair_head();
            put_value();
            put_space();
            put(REQ_BYTE, ",");
        end
        // the text always closes with one outcome, chosen at random
        ending = 4'($urandom_range(0, 14));
        case (ending)
            ERR_EOT_OBJ: put_end();
            ERR_KEY_QUOTE: put(REQ_BYTE, any_byte_but("}\"", 1'b1));
            ERR_EOT_ESC, ERR_BAD_ESC, ERR_UNTERM:
            begin
                if ($urandom_range(0, 1))
                    put_pair_head();
                put(REQ_BYTE, "\"");
                put_chars(6);
                if (ending == ERR_UNTERM)
                    put_end();
                else
                begin
                    put(REQ_BYTE, "\\");
                    if (ending == ERR_EOT_ESC)
                        put_end();
                    else
                        put(REQ_BYTE, any_byte_but(escape_letters, 1'b0));
                end
            end
            ERR_COLON:
            begin
                put_key();
                put_space();
                if ($urandom_range(0, 1))
                    put_end();
                else
                    put(REQ_BYTE, any_byte_but(":", 1'b1));
            end
            ERR_NO_VALUE:
            begin
                put_pair_head();
                put_end();
            end
            ERR_BAD_VALUE:
            begin
                put_pair_head();
                case ($urandom_range(0, 3))
                    0: put(REQ_BYTE, any_byte_but("\"tfn+-.0123456789", 1'b1));
                    1:
                    begin
                        w = spelled_literal(2'($urandom_range(0, 2)));
                        cut = $urandom_range(1, w.len() - 1);
                        put_text(w.substr(0, cut - 1));
                        if ($urandom_range(0, 1))
                            put_end();
                        else
                            put(REQ_BYTE, any_byte_but(w.substr(cut, cut), 1'b0));
                    end
                    2:
                    begin
                        put(REQ_BYTE, starts[$urandom_range(0, 2)]);
                        if ($urandom_range(0, 1))
                            put_end();
                        else
                            put(REQ_BYTE, any_byte_but("0123456789.", 1'b0));
                    end
                    default:
                    begin
                        put_digit();
                        put(REQ_BYTE, $urandom_range(0, 1) ? "e" : "E");
                        put_sign();
                        if ($urandom_range(0, 1))
                            put_end();
                        else
                            put(REQ_BYTE, any_byte_but("0123456789+-", 1'b0));
                    end
                endcase
            end
            ERR_EOT_VALUE:
            begin
                put_pair_head();
                put_value();
                put_space();
                put_end();
            end
            ERR_SEPARATOR:
            begin
                put_pair_head();
                put_value();
                put_space();
                put(REQ_BYTE, any_byte_but(",}0123456789.eE+-", 1'b1));
            end
            ERR_TRAILING:
            begin
                put(REQ_BYTE, "}");
                put_space();
                put(REQ_BYTE, any_byte_but("", 1'b1));
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    put_pair_head();
                    put_value();
                    put_space();
                end
                put(REQ_BYTE, "}");
                put_space();
                put_end();
            end
        endcase
        // outcome must now hold for anything that follows
        repeat (HOLD_WORDS) put($urandom_range(0, 1) == 1, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic steady();
        return calm_stretch || (text_q.size() < CALM_TAIL);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            calm_stretch <= ~calm_stretch;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                prediction = tokenize_word(on_wire.rt, on_wire.b);
                expected_tokens = {expected_tokens,
                                   (on_wire.typed ? on_wire.want : prediction)};
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (text_q.size() != 0 && (steady() || $urandom_range(0, 7) != 0))
                begin
                    on_wire = text_q.pop_front();
                    req_valid <= 1'b1;
                    req_type <= on_wire.rt;
                    data_byte <= on_wire.b;
                end
                else
                begin
                    req_valid <= 1'b0;
                    if (text_q.size() != 0)
                        send_gap = $urandom_range(0, 13);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = '{out_kind, out_char, parse_status, error_code};
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d char %02h status %0d error %0d",
                                 got.kind, got.ch, got.status, got.err);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch (exp/got): kind %0d/%0d char %02h/%02h",
                                      " status %0d/%0d error %0d/%0d"},
                                     want.kind, got.kind, want.ch, got.ch,
                                     want.status, got.status, want.err, got.err);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!steady() && $urandom_range(0, 9) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(0, 13);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        build_text();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (text_q.size() != 0 || req_valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("flat_json_object_tokenizer_test OK");
        else
            $display("flat_json_object_tokenizer_test NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("flat_json_object_tokenizer_test NOT OK");
        $finish;
    end

endmodule
